>>> rtl/tdg_pkg.sv
// Shared types, register indexes and constants of the target deduplication gate.
package tdg_pkg;

  localparam int unsigned CFG_DATA_W  = 16;
  localparam int unsigned CFG_IDX_W   = 3;
  localparam int unsigned COORD_W     = 16;
  localparam int unsigned COUNT_OUT_W = 7;
  localparam int unsigned ENTRY_W     = 3 * COORD_W;

  typedef logic [CFG_IDX_W-1:0] cfg_idx_t;

  localparam cfg_idx_t CFG_MAX_XY     = 3'd0;
  localparam cfg_idx_t CFG_MIN_Z      = 3'd1;
  localparam cfg_idx_t CFG_MAX_Z      = 3'd2;
  localparam cfg_idx_t CFG_DUP_RADIUS = 3'd3;
  localparam cfg_idx_t CFG_HOLD_TICKS = 3'd4;

  localparam logic [14:0]        RST_MAX_XY     = 15'd4000;
  localparam logic signed [15:0] RST_MIN_Z      = -16'sd2000;
  localparam logic signed [15:0] RST_MAX_Z      = 16'sd500;
  localparam logic [14:0]        RST_DUP_RADIUS = 15'd300;
  localparam logic [15:0]        RST_HOLD_TICKS = 16'd10;
  localparam logic [15:0]        HOLD_CNT_MAX   = 16'hFFFF;

  typedef enum logic [2:0] {
    ST_ACCEPT = 3'd0,
    ST_RANGE  = 3'd1,
    ST_DUP    = 3'd2,
    ST_FULL   = 3'd3,
    ST_GATE   = 3'd4,
    ST_TICK   = 3'd5
  } status_e;

  typedef struct packed {
    logic    load;
    logic    scan_start;
    logic    scan_run;
    logic    finish;
    status_e code;
  } ctrl_cmd_t;

  typedef struct packed {
    logic is_tick;
    logic gate_open;
    logic out_of_range;
    logic scan_hit;
    logic scan_done;
    logic table_full;
    logic out_free;
  } ctrl_sts_t;

endpackage

>>> rtl/tdg_in_if.sv
// Input channel carrying target reports and ticks.
interface tdg_in_if;
  logic               valid;
  logic               ready;
  logic               cmd;
  logic signed [15:0] x_mm;
  logic signed [15:0] y_mm;
  logic signed [15:0] z_mm;
  logic               gate_open;

  modport source(output valid, cmd, x_mm, y_mm, z_mm, gate_open, input ready);
  modport sink(input valid, cmd, x_mm, y_mm, z_mm, gate_open, output ready);
endinterface

>>> rtl/tdg_out_if.sv
// Output channel carrying one result per transaction.
interface tdg_out_if;
  logic       valid;
  logic       ready;
  logic [2:0] status;
  logic [6:0] target_count;
  logic       holding;
  logic       seen_flag;
  logic       done_flag;

  modport source(output valid, status, target_count, holding, seen_flag, done_flag,
                 input ready);
  modport sink(input valid, status, target_count, holding, seen_flag, done_flag,
               output ready);
endinterface

>>> rtl/tdg_ctrl.sv
// State machine sequencing tick/gate check, range check, table scan and result.
module tdg_ctrl (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  input  tdg_pkg::ctrl_sts_t sts_i,
  output tdg_pkg::ctrl_cmd_t cmd_o
);

  typedef enum logic [4:0] {
    S_IDLE  = 5'b00001,
    S_SQ    = 5'b00010,
    S_CHECK = 5'b00100,
    S_SCAN  = 5'b01000,
    S_FIN   = 5'b10000
  } state_e;

  state_e           state_q, state_d;
  tdg_pkg::status_e code_q, code_d;

  always_comb begin
    state_d          = state_q;
    code_d           = code_q;
    in_ready_o       = 1'b0;
    cmd_o            = '0;
    cmd_o.code       = code_q;
    case (state_q)
      S_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.load = 1'b1;
          state_d    = S_SQ;
        end
      end
      S_SQ: begin
        if (sts_i.is_tick) begin
          code_d  = tdg_pkg::ST_TICK;
          state_d = S_FIN;
        end else if (!sts_i.gate_open) begin
          code_d  = tdg_pkg::ST_GATE;
          state_d = S_FIN;
        end else begin
          state_d = S_CHECK;
        end
      end
      S_CHECK: begin
        if (sts_i.out_of_range) begin
          code_d  = tdg_pkg::ST_RANGE;
          state_d = S_FIN;
        end else begin
          cmd_o.scan_start = 1'b1;
          state_d          = S_SCAN;
        end
      end
      S_SCAN: begin
        cmd_o.scan_run = 1'b1;
        if (sts_i.scan_hit) begin
          code_d  = tdg_pkg::ST_DUP;
          state_d = S_FIN;
        end else if (sts_i.scan_done) begin
          code_d  = sts_i.table_full ? tdg_pkg::ST_FULL : tdg_pkg::ST_ACCEPT;
          state_d = S_FIN;
        end
      end
      S_FIN: begin
        if (sts_i.out_free) begin
          cmd_o.finish = 1'b1;
          state_d      = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      code_q  <= tdg_pkg::ST_TICK;
    end else begin
      state_q <= state_d;
      code_q  <= code_d;
    end
  end

endmodule

>>> rtl/tdg_datapath.sv
// Datapath with configuration, target table, distance units, hold state and result register.
module tdg_datapath #(
  parameter int unsigned TABLE_DEPTH = 64
) (
  input  logic                                  clk_i,
  input  logic                                  rst_ni,
  input  logic                                  cfg_we_i,
  input  logic [tdg_pkg::CFG_IDX_W-1:0]         cfg_idx_i,
  input  logic [tdg_pkg::CFG_DATA_W-1:0]        cfg_data_i,
  input  logic                                  in_cmd_i,
  input  logic signed [tdg_pkg::COORD_W-1:0]    in_x_i,
  input  logic signed [tdg_pkg::COORD_W-1:0]    in_y_i,
  input  logic signed [tdg_pkg::COORD_W-1:0]    in_z_i,
  input  logic                                  in_gate_i,
  input  logic                                  out_ready_i,
  output logic                                  out_valid_o,
  output logic [2:0]                            out_status_o,
  output logic [tdg_pkg::COUNT_OUT_W-1:0]       out_count_o,
  output logic                                  out_holding_o,
  output logic                                  out_seen_o,
  output logic                                  out_done_o,
  input  tdg_pkg::ctrl_cmd_t                    cmd_i,
  output tdg_pkg::ctrl_sts_t                    sts_o
);

  localparam int unsigned CNT_W = $clog2(TABLE_DEPTH + 1);
  localparam int unsigned IDX_W = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;

  logic [14:0]        max_xy_q;
  logic signed [15:0] min_z_q;
  logic signed [15:0] max_z_q;
  logic [14:0]        dup_rad_q;
  logic [15:0]        hold_ticks_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      max_xy_q     <= tdg_pkg::RST_MAX_XY;
      min_z_q      <= tdg_pkg::RST_MIN_Z;
      max_z_q      <= tdg_pkg::RST_MAX_Z;
      dup_rad_q    <= tdg_pkg::RST_DUP_RADIUS;
      hold_ticks_q <= tdg_pkg::RST_HOLD_TICKS;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        tdg_pkg::CFG_MAX_XY:     max_xy_q     <= cfg_data_i[14:0];
        tdg_pkg::CFG_MIN_Z:      min_z_q      <= cfg_data_i;
        tdg_pkg::CFG_MAX_Z:      max_z_q      <= cfg_data_i;
        tdg_pkg::CFG_DUP_RADIUS: dup_rad_q    <= cfg_data_i[14:0];
        tdg_pkg::CFG_HOLD_TICKS: hold_ticks_q <= cfg_data_i;
        default: begin
        end
      endcase
    end
  end

  logic               cmd_q;
  logic               gate_q;
  logic signed [15:0] x_q;
  logic signed [15:0] y_q;
  logic signed [15:0] z_q;

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      cmd_q  <= in_cmd_i;
      gate_q <= in_gate_i;
      x_q    <= in_x_i;
      y_q    <= in_y_i;
      z_q    <= in_z_i;
    end
  end

  logic signed [31:0] sqx_full;
  logic signed [31:0] sqy_full;
  logic [31:0]        px_q;
  logic [31:0]        py_q;
  logic [29:0]        lim_q;
  logic [29:0]        rad_q;
  logic [32:0]        pos_sum;

  assign sqx_full = x_q * x_q;
  assign sqy_full = y_q * y_q;

  always_ff @(posedge clk_i) begin
    px_q  <= sqx_full;
    py_q  <= sqy_full;
    lim_q <= max_xy_q * max_xy_q;
    rad_q <= dup_rad_q * dup_rad_q;
  end

  assign pos_sum = {1'b0, px_q} + {1'b0, py_q};

  localparam int unsigned ENTRY_W_L = tdg_pkg::ENTRY_W;

  logic [ENTRY_W_L-1:0] mem_q [TABLE_DEPTH];

  logic [CNT_W-1:0]     count_q, count_d;
  logic [CNT_W-1:0]     ri_q;
  logic                 v1_q;
  logic                 v2_q;
  logic                 issue;
  logic [ENTRY_W_L-1:0] rd_q;
  logic                 mem_we;
  logic signed [15:0]   tx;
  logic signed [15:0]   ty;
  logic signed [16:0]   dx;
  logic signed [16:0]   dy;
  logic signed [33:0]   dx_sq;
  logic signed [33:0]   dy_sq;
  logic [31:0]          dsx_q;
  logic [31:0]          dsy_q;
  logic [32:0]          d_sum;

  assign issue = cmd_i.scan_run && (ri_q < count_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ri_q <= '0;
      v1_q <= 1'b0;
      v2_q <= 1'b0;
    end else if (cmd_i.scan_start) begin
      ri_q <= '0;
      v1_q <= 1'b0;
      v2_q <= 1'b0;
    end else begin
      if (issue) begin
        ri_q <= ri_q + 1'b1;
      end
      v1_q <= issue;
      v2_q <= v1_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem_q[count_q[IDX_W-1:0]] <= {x_q, y_q, z_q};
    end
    rd_q <= mem_q[ri_q[IDX_W-1:0]];
  end

  assign tx    = rd_q[47:32];
  assign ty    = rd_q[31:16];
  assign dx    = {tx[15], tx} - {x_q[15], x_q};
  assign dy    = {ty[15], ty} - {y_q[15], y_q};
  assign dx_sq = dx * dx;
  assign dy_sq = dy * dy;

  always_ff @(posedge clk_i) begin
    dsx_q <= dx_sq[31:0];
    dsy_q <= dy_sq[31:0];
  end

  assign d_sum = {1'b0, dsx_q} + {1'b0, dsy_q};

  assign sts_o.is_tick      = cmd_q;
  assign sts_o.gate_open    = gate_q;
  assign sts_o.out_of_range = (pos_sum > {3'b000, lim_q}) || (z_q < min_z_q) ||
                              (z_q > max_z_q);
  assign sts_o.scan_hit     = v2_q && (d_sum < {3'b000, rad_q});
  assign sts_o.scan_done    = (ri_q >= count_q) && !v1_q && !v2_q;
  assign sts_o.table_full   = (count_q == CNT_W'(TABLE_DEPTH));

  logic        hold_q, hold_d;
  logic        seen_q, seen_d;
  logic        done_q, done_d;
  logic [15:0] hcnt_q, hcnt_d;
  logic [15:0] hcnt_inc;

  assign hcnt_inc = (hcnt_q < tdg_pkg::HOLD_CNT_MAX) ? hcnt_q + 16'd1 : hcnt_q;
  assign mem_we   = cmd_i.finish && (cmd_i.code == tdg_pkg::ST_ACCEPT);

  always_comb begin
    count_d = count_q;
    hold_d  = hold_q;
    seen_d  = seen_q;
    done_d  = done_q;
    hcnt_d  = hcnt_q;
    if (cmd_i.finish) begin
      case (cmd_i.code)
        tdg_pkg::ST_ACCEPT: begin
          count_d = count_q + 1'b1;
          if (!hold_q) begin
            hold_d = 1'b1;
            seen_d = 1'b1;
            done_d = 1'b0;
            hcnt_d = '0;
          end
        end
        tdg_pkg::ST_TICK: begin
          if (hold_q) begin
            hcnt_d = hcnt_inc;
            if (hcnt_inc >= hold_ticks_q) begin
              done_d = 1'b1;
              hold_d = 1'b0;
            end
          end
        end
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q <= '0;
      hold_q  <= 1'b0;
      seen_q  <= 1'b0;
      done_q  <= 1'b0;
      hcnt_q  <= '0;
    end else begin
      count_q <= count_d;
      hold_q  <= hold_d;
      seen_q  <= seen_d;
      done_q  <= done_d;
      hcnt_q  <= hcnt_d;
    end
  end

  logic out_valid_q;

  assign sts_o.out_free = !out_valid_q || out_ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.finish) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.finish) begin
      out_status_o  <= cmd_i.code;
      out_count_o   <= tdg_pkg::COUNT_OUT_W'(count_d);
      out_holding_o <= hold_d;
      out_seen_o    <= seen_d;
      out_done_o    <= done_d;
    end
  end

  assign out_valid_o = out_valid_q;

endmodule

>>> rtl/target_dedup_gate.sv
// Top level of the target deduplication gate: controller, datapath and channel ports.
//
//   Channel   Direction  Carries
//   in_i      sink       cmd, x_mm, y_mm, z_mm, gate_open
//   out_o     source     status, target_count, holding, seen_flag, done_flag
//   cfg_*     write      register index and data, no read-back
//
// A tick or a report with the gate closed skips the range check and the table scan.
// A target report in range also runs a table scan; the table scan reads one
// stored entry per cycle through the single read port of the table memory.
// Reset clears the flags, the count and the hold; table entries are not cleared.
// A new transaction is taken while the previous result waits in the output register.
module target_dedup_gate #(
  parameter int unsigned TABLE_DEPTH = 64
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  tdg_in_if.sink                         in_i,
  tdg_out_if.source                      out_o,
  input  logic                           cfg_we_i,
  input  logic [tdg_pkg::CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [tdg_pkg::CFG_DATA_W-1:0] cfg_data_i
);

  tdg_pkg::ctrl_cmd_t cmd;
  tdg_pkg::ctrl_sts_t sts;
  logic               in_ready;

  assign in_i.ready = in_ready;

  tdg_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_i.valid),
    .in_ready_o (in_ready),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  tdg_datapath #(
    .TABLE_DEPTH (TABLE_DEPTH)
  ) u_datapath (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we_i),
    .cfg_idx_i     (cfg_idx_i),
    .cfg_data_i    (cfg_data_i),
    .in_cmd_i      (in_i.cmd),
    .in_x_i        (in_i.x_mm),
    .in_y_i        (in_i.y_mm),
    .in_z_i        (in_i.z_mm),
    .in_gate_i     (in_i.gate_open),
    .out_ready_i   (out_o.ready),
    .out_valid_o   (out_o.valid),
    .out_status_o  (out_o.status),
    .out_count_o   (out_o.target_count),
    .out_holding_o (out_o.holding),
    .out_seen_o    (out_o.seen_flag),
    .out_done_o    (out_o.done_flag),
    .cmd_i         (cmd),
    .sts_o         (sts)
  );

`ifndef ASSERT_OFF
  a_busy_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_i.valid && in_i.ready) |=> !in_i.ready)
    else $error("Input was ready again right after a transaction.");

  a_hold_done_exclusive: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_o.valid |-> !(out_o.holding && out_o.done_flag))
    else $error("Result shows a running hold together with done.");

  a_hold_implies_seen: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_o.valid && out_o.holding) |-> out_o.seen_flag)
    else $error("Result shows a hold without the seen flag.");

  a_accept_holds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_o.valid && (out_o.status == tdg_pkg::ST_ACCEPT)) |-> out_o.holding)
    else $error("Accepted target did not leave a hold running.");
`endif

endmodule
